FILE: rtl/fqss_pkg.sv
// fqss_pkg: shared types and constants for the search/sort queue.
// Used by fqss_cell, fqss_ctrl and fifo_queue_search_sort_top.
`timescale 1ns / 1ps

package fqss_pkg;

  // Default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Port widths fixed by the interface
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SORT   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_SORT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;  // odd-even sort phase: 0 pairs (0,1),(2,3)..; 1 pairs (1,2)..
  } cell_cmd_t;

endpackage

FILE: rtl/fifo_queue_search_sort_top.sv
// fifo_queue_search_sort_top: bounded queue with search and ascending sort,
// built as a chain of fqss_cell entries run by fqss_ctrl; uses fqss_pkg.
// Flow: enqueue/dequeue go from accept through S_DONE to out_valid; search and sort
//   first walk the cell chain once in S_SEARCH or S_SORT (DEPTH steps), then S_DONE.
// One command at a time: S_DONE waits for a free result register before returning to idle.
// Reset (rst_n, synchronous, active low) empties the queue; stored words are not cleared.
`timescale 1ns / 1ps

module fifo_queue_search_sort_top
  import fqss_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [VALUE_W-1:0]  out_data_out,
  output logic [POS_W-1:0]    out_position,
  output logic [POS_W-1:0]    out_fill_level
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] in_word;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  cell_cmd_t             cmd;
  logic [CNT_W-1:0]      count;

  // Take the word in its low DATA_WIDTH bits
  assign in_word = DATA_WIDTH'(in_value);

  fqss_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_word        (in_word),
    .front_word     (cell_q[0]),
    .cmd            (cmd),
    .count          (count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_position   (out_position),
    .out_fill_level (out_fill_level)
  );

  // Cell chain, closed into a ring so a full walk restores the order
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqss_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .load_word (in_word),
      .prev_word (cell_q[(i + DEPTH - 1) % DEPTH]),
      .next_word (cell_q[(i + 1) % DEPTH]),
      .word      (cell_q[i])
    );
  end

endmodule

FILE: rtl/fqss_cell.sv
// fqss_cell: one storage cell of the queue chain (one entry, front at cell 0).
// Depends on fqss_pkg for the cell command type.
`timescale 1ns / 1ps

module fqss_cell
  import fqss_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic [DATA_WIDTH-1:0] next_word,
  output logic [DATA_WIDTH-1:0] word
);

  localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1_C = CNT_W'(IDX + 1);
  localparam logic             PARITY   = 1'(IDX % 2);
  localparam logic             IS_FIRST = (IDX == 0);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Pick next content: load, take the neighbor behind, or compare-swap
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_LOAD: begin
        if (count == IDX_C) data_nxt = load_word;
      end
      CELL_SHIFT: begin
        data_nxt = next_word;
      end
      CELL_SORT: begin
        if (cmd.phase == PARITY) begin
          // left of a pair: keep the smaller word
          if ((count > IDX_P1_C) && (data_r > next_word)) data_nxt = next_word;
        end else begin
          // right of a pair: keep the larger word
          if (!IS_FIRST && (count > IDX_C) && (prev_word > data_r)) data_nxt = prev_word;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word = data_r;

endmodule

FILE: rtl/fqss_ctrl.sv
// fqss_ctrl: command sequencer, entry count and result register of the queue.
// Depends on fqss_pkg; drives the cell chain built in the top level.
`timescale 1ns / 1ps

module fqss_ctrl
  import fqss_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int STP_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [DATA_WIDTH-1:0] in_word,
  input  logic [DATA_WIDTH-1:0] front_word,
  output cell_cmd_t             cmd,
  output logic [CNT_W-1:0]      count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [VALUE_W-1:0]    out_data_out,
  output logic [POS_W-1:0]      out_position,
  output logic [POS_W-1:0]      out_fill_level
);

  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);
  localparam logic [STP_W-1:0] STP_LAST = STP_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SORT   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [STP_W-1:0]      stp_r, stp_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  found_r, found_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;
  logic [DATA_WIDTH-1:0] pend_data_r, pend_data_nxt;
  logic [CNT_W-1:0]      pend_pos_r, pend_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]      out_fill_r, out_fill_nxt;
  logic                  out_free;
  logic                  in_beat;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequence one command: quick ops finish at accept, search/sort walk the chain
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    stp_nxt         = stp_r;
    key_nxt         = key_r;
    found_nxt       = found_r;
    pend_status_nxt = pend_status_r;
    pend_data_nxt   = pend_data_r;
    pend_pos_nxt    = pend_pos_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_pos_nxt     = out_pos_r;
    out_fill_nxt    = out_fill_r;
    cmd             = '{op: CELL_HOLD, phase: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pend_status_nxt = ST_OK;
          pend_data_nxt   = '0;
          pend_pos_nxt    = '0;
          state_nxt       = S_DONE;
          case (in_mode)
            MODE_ENQ: begin
              if (count_r == DEPTH_C) begin
                pend_status_nxt = ST_FULL;
              end else begin
                cmd.op    = CELL_LOAD;
                count_nxt = count_r + ONE_C;
              end
            end
            MODE_DEQ: begin
              if (count_r == '0) begin
                pend_status_nxt = ST_EMPTY;
              end else begin
                pend_data_nxt = front_word;
                cmd.op        = CELL_SHIFT;
                count_nxt     = count_r - ONE_C;
              end
            end
            MODE_SEARCH: begin
              if (count_r == '0) begin
                pend_status_nxt = ST_EMPTY;
              end else begin
                key_nxt         = in_word;
                stp_nxt         = '0;
                found_nxt       = 1'b0;
                pend_status_nxt = ST_NOT_FOUND;
                state_nxt       = S_SEARCH;
              end
            end
            default: begin
              if (count_r == '0) begin
                pend_status_nxt = ST_EMPTY;
              end else begin
                stp_nxt   = '0;
                state_nxt = S_SORT;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        // rotate the full chain once; cell 0 shows entry stp_r each cycle
        cmd.op = CELL_SHIFT;
        if (!found_r && (CNT_W'(stp_r) < count_r) && (front_word == key_r)) begin
          found_nxt       = 1'b1;
          pend_status_nxt = ST_OK;
          pend_pos_nxt    = CNT_W'(stp_r) + ONE_C;
        end
        if (stp_r == STP_LAST) state_nxt = S_DONE;
        else stp_nxt = stp_r + STP_W'(1);
      end
      S_SORT: begin
        // odd-even transposition: DEPTH phases sort any fill level
        cmd.op    = CELL_SORT;
        cmd.phase = stp_r[0];
        if (stp_r == STP_LAST) state_nxt = S_DONE;
        else stp_nxt = stp_r + STP_W'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_data_nxt   = VALUE_W'(pend_data_r);
          out_pos_nxt    = POS_W'(pend_pos_r);
          out_fill_nxt   = POS_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    stp_r         <= stp_nxt;
    key_r         <= key_nxt;
    found_r       <= found_nxt;
    pend_status_r <= pend_status_nxt;
    pend_data_r   <= pend_data_nxt;
    pend_pos_r    <= pend_pos_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_pos_r     <= out_pos_nxt;
    out_fill_r    <= out_fill_nxt;
  end

  assign count          = count_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_position   = out_pos_r;
  assign out_fill_level = out_fill_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_mode == MODE_SEARCH) && (count_r != '0)) |=> (state_r == S_SEARCH))
    else $error("search did not start");

  a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SORT || state_r == S_SEARCH) && (stp_r != STP_LAST)) |=>
      (state_r == $past(state_r)))
    else $error("chain walk ended early");

  a_done_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("pending result not issued");

  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_pos_r == '0))
    else $error("position set on failed command");

endmodule

FILE: sim/fifo_queue_search_sort_top_tb.sv
// fifo_queue_search_sort_top_tb: self-checking bench for the search/sort queue.
// A queue-based predictor tracks every accepted command and checks each result.
// Depends on fqss_pkg and fifo_queue_search_sort_top.
`timescale 1ns / 1ps

module fifo_queue_search_sort_top_tb;
  import fqss_pkg::*;

  localparam int QDEPTH    = DEPTH_DEF;
  localparam int BLOCKS    = 15;
  localparam int BLOCK_LEN = 88;
  localparam int STALL_LEN = 300;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    fill_level;
  } result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_ENQ;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_data_out;
  logic [POS_W-1:0]    out_position;
  logic [POS_W-1:0]    out_fill_level;

  cmd_t               cmd_backlog[$];
  result_t            result_fifo[$];
  logic [VALUE_W-1:0] queue_image[$];
  logic [VALUE_W-1:0] word_pool[8];

  cmd_t    next_cmd;
  result_t want;
  int      n_pushed = 0;
  int      n_accepted = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  int      stall_left = 0;
  logic    stall_kick = 1'b0;
  logic    calm;

  fifo_queue_search_sort_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_position  (out_position),
    .out_fill_level(out_fill_level)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // No idling on either side in this window of accepted beats
  assign calm = (n_accepted >= 500) && (n_accepted < 700);

  // Apply one command to the queue image and record the result it must give
  function automatic void queue_apply(input logic [MODE_W-1:0] mode,
                                      input logic [VALUE_W-1:0] value);
    result_t            r;
    int                 i;
    int                 limit;
    logic               swapped;
    logic [VALUE_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_ENQ: begin
        if (queue_image.size() >= QDEPTH) r.status = ST_FULL;
        else queue_image.push_back(value);
      end
      MODE_DEQ: begin
        if (queue_image.size() == 0) r.status = ST_EMPTY;
        else r.data_out = queue_image.pop_front();
      end
      MODE_SEARCH: begin
        if (queue_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < queue_image.size(); i++) begin
            if (r.status == ST_NOT_FOUND && queue_image[i] == value) begin
              r.status   = ST_OK;
              r.position = POS_W'(i + 1);
            end
          end
        end
      end
      default: begin
        if (queue_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // bubble sort, unsigned ascending, front first
          limit   = queue_image.size();
          swapped = 1'b1;
          while (swapped && limit > 1) begin
            swapped = 1'b0;
            for (i = 0; i + 1 < limit; i++) begin
              if (queue_image[i] > queue_image[i+1]) begin
                t                = queue_image[i];
                queue_image[i]   = queue_image[i+1];
                queue_image[i+1] = t;
                swapped          = 1'b1;
              end
            end
            limit--;
          end
        end
      end
    endcase
    r.fill_level = POS_W'(queue_image.size());
    result_fifo.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                                      input logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
    cmd_backlog.push_back('{mode, value});
    n_pushed++;
  endtask

  // Half the words come from a small pool, so searches hit and sorts see duplicates
  function automatic logic [VALUE_W-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 50) return word_pool[$urandom_range(7)];
    if (r < 53) return '0;
    if (r < 56) return '1;
    if (r < 58) return 32'h8000_0000;
    if (r < 60) return 32'h0000_0001;
    return $urandom;
  endfunction

  // Driver: present the next command, predict on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_apply(in_mode, in_value);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          next_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_cmd.mode;
          in_value <= next_cmd.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (stall_kick) stall_left <= STALL_LEN;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $error("result beat with no command outstanding");
          n_errors++;
        end else begin
          want = result_fifo.pop_front();
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_status));
          check_field("data_out", want.data_out, out_data_out);
          check_field("position", VALUE_W'(want.position), VALUE_W'(out_position));
          check_field("fill_level", VALUE_W'(want.fill_level), VALUE_W'(out_fill_level));
          n_checked <= n_checked + 1;
        end
      end
      out_ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 8);
    end
  end

  // Stimulus
  initial begin
    int                 blk;
    int                 k;
    int                 r;
    int                 enq_cut;
    logic [MODE_W-1:0]  mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty-queue cases
    add_cmd(MODE_DEQ, 32'h1234_5678);
    add_cmd(MODE_SEARCH, 32'h0);
    add_cmd(MODE_SORT, 32'hFFFF_FFFF);
    // search hit at the last entry, and a miss
    add_cmd(MODE_ENQ, 32'hFFFF_FFFF);
    add_cmd(MODE_ENQ, 32'h0);
    add_cmd(MODE_SEARCH, 32'h0);
    add_cmd(MODE_SEARCH, 32'h0000_0007);
    // fill to the top with descending words, then overflow
    for (k = 0; k < QDEPTH - 2; k++) add_cmd(MODE_ENQ, 32'hF000_0000 - k * 32'h1111_1111);
    add_cmd(MODE_ENQ, 32'hAAAA_5555);
    add_cmd(MODE_SORT, 32'h0);
    add_cmd(MODE_SEARCH, 32'hFFFF_FFFF);
    add_cmd(MODE_DEQ, 32'h0);
    wait (n_accepted == n_pushed && n_checked == n_pushed);

    // random phases: fill-heavy, drain-heavy, balanced
    for (blk = 0; blk < BLOCKS; blk++) begin
      wait (n_pushed - n_accepted < 16);
      if (blk == 3) begin
        @(negedge clk) stall_kick = 1'b1;
        @(negedge clk) stall_kick = 1'b0;
      end
      if (blk == 8) wait (n_accepted == n_pushed && n_checked == n_pushed);
      for (k = 0; k < 8; k++) word_pool[k] = $urandom;
      case (blk % 3)
        0:       enq_cut = 55;
        1:       enq_cut = 15;
        default: enq_cut = 35;
      endcase
      for (k = 0; k < BLOCK_LEN; k++) begin
        r = $urandom_range(99);
        if (r < enq_cut)  mode = MODE_ENQ;
        else if (r < 65)  mode = MODE_DEQ;
        else if (r < 88)  mode = MODE_SEARCH;
        else              mode = MODE_SORT;
        add_cmd(mode, pick_word());
      end
    end

    wait (n_accepted == n_pushed && n_checked == n_pushed);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
